FILE: rtl/core/vcc_pkg.sv
// Shared types and constants for the clamped-border 3D convolution block.
`timescale 1ns / 1ps

package vcc_pkg;

   // Field widths of the request and response payloads
   localparam int KIND_W   = 2;
   localparam int POS_W    = 5;
   localparam int SAMPLE_W = 16;
   localparam int OUT_W    = 38;

   // Configuration register widths
   localparam int SIZE_W   = 6;
   localparam int TAPS_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_TAP   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_VOXEL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VOL_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOL_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOL_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPS_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPS_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPS_Z = 3'd5;

   // Register reset values
   localparam logic [SIZE_W-1:0] VOL_RESET  = 6'd32;
   localparam logic [TAPS_W-1:0] TAPS_RESET = 3'd1;

   // Saturation limits of the result
   localparam logic signed [OUT_W-1:0] SUM_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] SUM_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef struct packed {
      logic [KIND_W-1:0]          kind;
      logic [POS_W-1:0]           pos_x;
      logic [POS_W-1:0]           pos_y;
      logic [POS_W-1:0]           pos_z;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] filtered;
      logic                    in_range;
   } rsp_type;

   // Effective (bounded) configuration
   typedef struct packed {
      logic [SIZE_W-1:0] vol_x;
      logic [SIZE_W-1:0] vol_y;
      logic [SIZE_W-1:0] vol_z;
      logic [TAPS_W-1:0] taps_x;
      logic [TAPS_W-1:0] taps_y;
      logic [TAPS_W-1:0] taps_z;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic wr_tap;
      logic wr_vox;
      logic start;
      logic issue;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_inside;
      logic last_tap;
      logic busy;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/core/vcc_csr.sv
// Configuration registers and their bounding to the supported ranges.
`timescale 1ns / 1ps

module vcc_csr import vcc_pkg::*; #(
   parameter int VOL_EDGE_MAX = 32,
   parameter int KER_EDGE_MAX = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  wr_index,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type               cfg
);

   logic [SIZE_W-1:0] vol_x_ff, vol_y_ff, vol_z_ff;
   logic [TAPS_W-1:0] taps_x_ff, taps_y_ff, taps_z_ff;

   function automatic logic [SIZE_W-1:0] bound_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (int'(v) > VOL_EDGE_MAX) begin
         r = SIZE_W'(VOL_EDGE_MAX);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [TAPS_W-1:0] bound_taps(input logic [TAPS_W-1:0] v);
      logic [TAPS_W-1:0] r;
      if (v == '0) begin
         r = TAPS_W'(1);
      end else if (int'(v) > KER_EDGE_MAX) begin
         r = TAPS_W'(KER_EDGE_MAX);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vol_x_ff  <= VOL_RESET;
         vol_y_ff  <= VOL_RESET;
         vol_z_ff  <= VOL_RESET;
         taps_x_ff <= TAPS_RESET;
         taps_y_ff <= TAPS_RESET;
         taps_z_ff <= TAPS_RESET;
      end else if (wr_en) begin
         case (wr_index)
            CSR_VOL_X:  vol_x_ff  <= wr_data;
            CSR_VOL_Y:  vol_y_ff  <= wr_data;
            CSR_VOL_Z:  vol_z_ff  <= wr_data;
            CSR_TAPS_X: taps_x_ff <= wr_data[TAPS_W-1:0];
            CSR_TAPS_Y: taps_y_ff <= wr_data[TAPS_W-1:0];
            CSR_TAPS_Z: taps_z_ff <= wr_data[TAPS_W-1:0];
            default: ;
         endcase
      end
   end

   // Zero reads as one, oversize reads as the edge maximum
   always_comb begin
      cfg.vol_x  = bound_size(vol_x_ff);
      cfg.vol_y  = bound_size(vol_y_ff);
      cfg.vol_z  = bound_size(vol_z_ff);
      cfg.taps_x = bound_taps(taps_x_ff);
      cfg.taps_y = bound_taps(taps_y_ff);
      cfg.taps_z = bound_taps(taps_z_ff);
   end

endmodule

FILE: rtl/core/vcc_ctrl.sv
// Sequencing state machine for writes and queries.
`timescale 1ns / 1ps

module vcc_ctrl import vcc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [KIND_W-1:0] req_kind,
   input  status_type        status,
   output logic              req_stall,
   output cmd_type           cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_TAP:   cmd.wr_tap = 1'b1;
                  KIND_VOXEL: cmd.wr_vox = 1'b1;
                  KIND_QUERY: begin
                     cmd.start = 1'b1;
                     state_in  = status.req_inside ? ST_RUN : ST_DONE;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (status.last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/vcc_dp.sv
// Datapath: tap and voxel memories, address generation, MAC and result register.
`timescale 1ns / 1ps

module vcc_dp import vcc_pkg::*; #(
   parameter int VOL_EDGE_MAX = 32,
   parameter int KER_EDGE_MAX = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  cfg_type    cfg,
   input  req_type    req_item,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_item,
   output status_type status
);

   localparam int VOL_DEPTH = VOL_EDGE_MAX * VOL_EDGE_MAX * VOL_EDGE_MAX;
   localparam int KER_DEPTH = KER_EDGE_MAX * KER_EDGE_MAX * KER_EDGE_MAX;
   localparam int VA_W      = $clog2(VOL_DEPTH);
   localparam int TA_W      = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
   localparam int PROD_W    = 2 * SAMPLE_W;
   localparam int SUM_W     = PROD_W + $clog2(KER_DEPTH) + 1;
   localparam int ACC_W     = (SUM_W > OUT_W) ? SUM_W : OUT_W;

   logic signed [SAMPLE_W-1:0] tap_mem [KER_DEPTH];
   logic signed [SAMPLE_W-1:0] vox_mem [VOL_DEPTH];

   logic [POS_W-1:0]  qx_ff, qy_ff, qz_ff;
   logic              inside_ff;
   logic [TAPS_W-1:0] tx_ff, ty_ff, tz_ff, tx_in, ty_in, tz_in;
   logic [TAPS_W-1:0] hx, hy, hz;
   logic [SIZE_W-1:0] cx, cy, cz;
   logic [TA_W-1:0]   tap_waddr, tap_raddr;
   logic [VA_W-1:0]   vox_waddr, vox_raddr;
   logic              tap_wr_ok, vox_wr_ok;

   logic signed [SAMPLE_W-1:0] tap_rd_ff, vox_rd_ff;
   logic                       rd_v_ff, prod_v_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [OUT_W-1:0]    sat_sum;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff;

   // Replicated border: clamp q + t - h into [0, size-1]
   function automatic logic [SIZE_W-1:0] clamp_coord(
      input logic [POS_W-1:0]  q,
      input logic [TAPS_W-1:0] t,
      input logic [TAPS_W-1:0] h,
      input logic [SIZE_W-1:0] size
   );
      logic signed [7:0] c;
      logic signed [7:0] lim;
      logic [SIZE_W-1:0] r;
      c   = signed'({3'b000, q}) + signed'({5'b00000, t}) - signed'({5'b00000, h});
      lim = signed'({2'b00, size}) - 8'sd1;
      if (c < 8'sd0) begin
         r = '0;
      end else if (c > lim) begin
         r = lim[SIZE_W-1:0];
      end else begin
         r = c[SIZE_W-1:0];
      end
      return r;
   endfunction

   // Write addresses straight from the request
   assign tap_wr_ok = (int'(req_item.pos_x) < KER_EDGE_MAX) &&
                      (int'(req_item.pos_y) < KER_EDGE_MAX) &&
                      (int'(req_item.pos_z) < KER_EDGE_MAX);
   assign vox_wr_ok = (int'(req_item.pos_x) < VOL_EDGE_MAX) &&
                      (int'(req_item.pos_y) < VOL_EDGE_MAX) &&
                      (int'(req_item.pos_z) < VOL_EDGE_MAX);
   assign tap_waddr = TA_W'(int'(req_item.pos_x) + KER_EDGE_MAX *
                      (int'(req_item.pos_y) + KER_EDGE_MAX * int'(req_item.pos_z)));
   assign vox_waddr = VA_W'(int'(req_item.pos_x) + VOL_EDGE_MAX *
                      (int'(req_item.pos_y) + VOL_EDGE_MAX * int'(req_item.pos_z)));

   // Read addresses for the current tap
   assign hx = cfg.taps_x >> 1;
   assign hy = cfg.taps_y >> 1;
   assign hz = cfg.taps_z >> 1;
   assign cx = clamp_coord(qx_ff, tx_ff, hx, cfg.vol_x);
   assign cy = clamp_coord(qy_ff, ty_ff, hy, cfg.vol_y);
   assign cz = clamp_coord(qz_ff, tz_ff, hz, cfg.vol_z);
   assign tap_raddr = TA_W'(int'(tx_ff) + KER_EDGE_MAX *
                      (int'(ty_ff) + KER_EDGE_MAX * int'(tz_ff)));
   assign vox_raddr = VA_W'(int'(cx) + VOL_EDGE_MAX *
                      (int'(cy) + VOL_EDGE_MAX * int'(cz)));

   // Tap memory
   always_ff @(posedge clock) begin
      if (cmd.wr_tap && tap_wr_ok) begin
         tap_mem[tap_waddr] <= req_item.sample;
      end
      tap_rd_ff <= tap_mem[tap_raddr];
   end

   // Voxel memory
   always_ff @(posedge clock) begin
      if (cmd.wr_vox && vox_wr_ok) begin
         vox_mem[vox_waddr] <= req_item.sample;
      end
      vox_rd_ff <= vox_mem[vox_raddr];
   end

   // Query coordinates
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         qx_ff <= req_item.pos_x;
         qy_ff <= req_item.pos_y;
         qz_ff <= req_item.pos_z;
      end
   end

   // Tap counters, x fastest
   always_comb begin
      tx_in = tx_ff;
      ty_in = ty_ff;
      tz_in = tz_ff;
      if (cmd.start) begin
         tx_in = '0;
         ty_in = '0;
         tz_in = '0;
      end else if (cmd.issue) begin
         if (tx_ff != cfg.taps_x - TAPS_W'(1)) begin
            tx_in = tx_ff + TAPS_W'(1);
         end else begin
            tx_in = '0;
            if (ty_ff != cfg.taps_y - TAPS_W'(1)) begin
               ty_in = ty_ff + TAPS_W'(1);
            end else begin
               ty_in = '0;
               tz_in = tz_ff + TAPS_W'(1);
            end
         end
      end
   end

   assign status.last_tap = (tx_ff == cfg.taps_x - TAPS_W'(1)) &&
                            (ty_ff == cfg.taps_y - TAPS_W'(1)) &&
                            (tz_ff == cfg.taps_z - TAPS_W'(1));

   // Multiply stage and accumulate stage
   always_comb begin
      acc_in = acc_ff;
      if (cmd.start) begin
         acc_in = '0;
      end else if (prod_v_ff) begin
         acc_in = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      tx_ff   <= tx_in;
      ty_ff   <= ty_in;
      tz_ff   <= tz_in;
      prod_ff <= tap_rd_ff * vox_rd_ff;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
         inside_ff <= 1'b0;
      end else begin
         rd_v_ff   <= cmd.issue;
         prod_v_ff <= rd_v_ff;
         if (cmd.start) begin
            inside_ff <= status.req_inside;
         end
      end
   end

   // Saturate the wide sum to the output range
   always_comb begin
      if (&acc_ff[ACC_W-1:OUT_W-1] || ~|acc_ff[ACC_W-1:OUT_W-1]) begin
         sat_sum = acc_ff[OUT_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sat_sum = SUM_MIN;
      end else begin
         sat_sum = SUM_MAX;
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_item_ff.filtered <= inside_ff ? sat_sum : '0;
         rsp_item_ff.in_range <= inside_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Status to the controller
   assign status.req_inside = ({1'b0, req_item.pos_x} < cfg.vol_x) &&
                              ({1'b0, req_item.pos_y} < cfg.vol_y) &&
                              ({1'b0, req_item.pos_z} < cfg.vol_z);
   assign status.busy       = rd_v_ff || prod_v_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

FILE: rtl/core/volume_conv_3d_clamped_top.sv
// Top level of the 3D convolution block with replicated volume border.
`timescale 1ns / 1ps

// Usage:
//   req_*  : request channel (valid/stall). Kind TAP writes a Q2.14 kernel tap,
//            kind VOXEL writes a 16-bit voxel, kind QUERY computes one output
//            voxel; any other kind is dropped without a response.
//   rsp_*  : response channel (valid/stall), one response per query.
//   csr_*  : register writes (valid/ready, always ready): volume size and kernel
//            size per axis. Write only while the block is idle.
//   A write leaves the block idle. A query with N = taps_x*taps_y*taps_z taps
//   runs one multiply-accumulate per cycle, one tap and one voxel read per
//   cycle from the two memories; the next request can be taken in the cycle
//   in which its response becomes valid. A query outside the volume skips
//   the MAC and responds with a zero sum and in_range low.
//   Requests are taken while an earlier response still waits; a finished
//   query waits in the controller while rsp_stall holds the response register.
//   Reset restores the register defaults and empties the response register.
//   Memory contents are undefined until written; no clearing pass is run.

module volume_conv_3d_clamped_top import vcc_pkg::*; #(
   parameter int VOL_EDGE_MAX = 32,
   parameter int KER_EDGE_MAX = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // Configuration registers
   vcc_csr #(
      .VOL_EDGE_MAX (VOL_EDGE_MAX),
      .KER_EDGE_MAX (KER_EDGE_MAX)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // Controller
   vcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_item.kind),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // Datapath
   vcc_dp #(
      .VOL_EDGE_MAX (VOL_EDGE_MAX),
      .KER_EDGE_MAX (KER_EDGE_MAX)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .req_item  (req_item),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .status    (status)
   );

   // The MAC pipeline is empty whenever a new request can be taken
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !status.busy)
      else $error("request taken while MAC pipeline busy");

   // A response never overwrites one that is still waiting
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || !rsp_stall))
      else $error("response register overwritten");

   // Tap reads are issued only while a query runs
   a_issue_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> req_stall)
      else $error("tap read issued while idle");

   // Out-of-volume responses carry a zero sum
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.in_range) |-> (rsp_item.filtered == '0))
      else $error("nonzero sum on out-of-range query");

endmodule

FILE: sim/tb_volume_conv_3d_clamped_top.sv
// Self-checking testbench for the clamped-border 3D convolution block.
`timescale 1ns / 1ps

module tb_volume_conv_3d_clamped_top;
   import vcc_pkg::*;

   localparam int VOL_EDGE         = 32;
   localparam int KER_EDGE         = 5;
   localparam int DRAIN_CYCLES     = 160;
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int RANDOM_PER_PHASE = 75;
   localparam int HOLD_CYCLES      = 800;
   localparam int MAX_REPORTS      = 10;

   // Kind that the block drops without a response
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

   // Fixed register settings: vol x/y/z, taps x/y/z as raw write data
   localparam int FIXED_PHASES = 7;
   localparam int fixed_cfg [FIXED_PHASES][6] = '{
      '{32,  1,  1, 5,  5,  5},
      '{ 1, 32,  1, 1,  5,  1},
      '{ 1,  1, 32, 2,  1,  4},
      '{ 0, 63,  0, 8, 15, 62},
      '{ 3,  5,  2, 4,  2,  5},
      '{33,  1,  2, 1,  1,  1},
      '{ 1,  1,  1, 5,  5,  5}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_item;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   volume_conv_3d_clamped_top #(
      .VOL_EDGE_MAX(VOL_EDGE),
      .KER_EDGE_MAX(KER_EDGE)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the block's stores and registers
   logic signed [SAMPLE_W-1:0] voxel_mirror [VOL_EDGE*VOL_EDGE*VOL_EDGE];
   logic signed [SAMPLE_W-1:0] tap_mirror [KER_EDGE*KER_EDGE*KER_EDGE];
   logic [SIZE_W-1:0] cur_vol_x = VOL_RESET, cur_vol_y = VOL_RESET, cur_vol_z = VOL_RESET;
   logic [TAPS_W-1:0] cur_taps_x = TAPS_RESET, cur_taps_y = TAPS_RESET;
   logic [TAPS_W-1:0] cur_taps_z = TAPS_RESET;

   // Requests waiting to be driven and sums waiting to come back
   req_type pending_reqs [$];
   rsp_type queued_sums [$];

   // Which entries the stimulus has written so far
   bit voxel_written [VOL_EDGE*VOL_EDGE*VOL_EDGE];
   bit tap_written [KER_EDGE*KER_EDGE*KER_EDGE];
   int gen_sx, gen_sy, gen_sz, gen_kx, gen_ky, gen_kz;

   bit      req_taken = 1'b0;
   int      failures = 0;
   int      rsp_seen = 0;
   int      cycle_count = 0;
   rsp_type want;

   int burst_left = 0, gap_left = 0;
   int hold_left = 0, next_hold_at = 120;
   int stall_mode = 0, mode_left = 0, stall_tick = 0;

   function automatic int eff_size(int raw, int hi);
      if (raw < 1) return 1;
      if (raw > hi) return hi;
      return raw;
   endfunction

   function automatic int voxel_addr(int x, int y, int z);
      return x + VOL_EDGE * (y + VOL_EDGE * z);
   endfunction

   function automatic int tap_addr(int x, int y, int z);
      return x + KER_EDGE * (y + KER_EDGE * z);
   endfunction

   function automatic int clamp_axis(int c, int size);
      if (c < 0) return 0;
      if (c > size - 1) return size - 1;
      return c;
   endfunction

   // Convolution sum of one output voxel, border replicated
   function automatic rsp_type filter_voxel(req_type r);
      int sx, sy, sz, kx, ky, kz, px, py, pz, cx, cy, cz;
      longint acc, lim;
      rsp_type res;
      sx = eff_size(int'(cur_vol_x), VOL_EDGE);
      sy = eff_size(int'(cur_vol_y), VOL_EDGE);
      sz = eff_size(int'(cur_vol_z), VOL_EDGE);
      kx = eff_size(int'(cur_taps_x), KER_EDGE);
      ky = eff_size(int'(cur_taps_y), KER_EDGE);
      kz = eff_size(int'(cur_taps_z), KER_EDGE);
      px = r.pos_x;
      py = r.pos_y;
      pz = r.pos_z;
      res = '0;
      if (px >= sx || py >= sy || pz >= sz) return res;
      acc = 0;
      for (int tz = 0; tz < kz; tz++) begin
         cz = clamp_axis(pz + tz - kz / 2, sz);
         for (int ty = 0; ty < ky; ty++) begin
            cy = clamp_axis(py + ty - ky / 2, sy);
            for (int tx = 0; tx < kx; tx++) begin
               cx = clamp_axis(px + tx - kx / 2, sx);
               acc += longint'(tap_mirror[tap_addr(tx, ty, tz)]) *
                      longint'(voxel_mirror[voxel_addr(cx, cy, cz)]);
            end
         end
      end
      lim = (longint'(1) <<< (OUT_W - 1)) - 1;
      if (acc > lim) acc = lim;
      if (acc < -lim - 1) acc = -lim - 1;
      res.filtered = acc[OUT_W-1:0];
      res.in_range = 1'b1;
      return res;
   endfunction

   // Sample value with the extremes weighted in
   function automatic int rand_sample();
      case ($urandom_range(0, 9))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return int'($urandom_range(0, 65535));
      endcase
   endfunction

   // Queue one request and track what it writes
   task automatic send_item(logic [KIND_W-1:0] kind, int x, int y, int z, int s);
      req_type r;
      r.kind   = kind;
      r.pos_x  = POS_W'(x);
      r.pos_y  = POS_W'(y);
      r.pos_z  = POS_W'(z);
      r.sample = SAMPLE_W'(s);
      if (kind == KIND_TAP && x < KER_EDGE && y < KER_EDGE && z < KER_EDGE)
         tap_written[tap_addr(x, y, z)] = 1'b1;
      if (kind == KIND_VOXEL)
         voxel_written[voxel_addr(x, y, z)] = 1'b1;
      pending_reqs.push_back(r);
   endtask

   // Wait until every request is taken, every sum is back and the block drained
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || queued_sums.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(int vx, int vy, int vz, int tx, int ty, int tz);
      wait_idle();
      write_csr(CSR_VOL_X, vx);
      write_csr(CSR_VOL_Y, vy);
      write_csr(CSR_VOL_Z, vz);
      write_csr(CSR_TAPS_X, tx);
      write_csr(CSR_TAPS_Y, ty);
      write_csr(CSR_TAPS_Z, tz);
      gen_sx = eff_size(vx & 63, VOL_EDGE);
      gen_sy = eff_size(vy & 63, VOL_EDGE);
      gen_sz = eff_size(vz & 63, VOL_EDGE);
      gen_kx = eff_size(tx & 7, KER_EDGE);
      gen_ky = eff_size(ty & 7, KER_EDGE);
      gen_kz = eff_size(tz & 7, KER_EDGE);
   endtask

   // Write every voxel and tap a query may read that is still unwritten
   task automatic fill_region();
      for (int z = 0; z < gen_sz; z++)
         for (int y = 0; y < gen_sy; y++)
            for (int x = 0; x < gen_sx; x++)
               if (!voxel_written[voxel_addr(x, y, z)])
                  send_item(KIND_VOXEL, x, y, z, rand_sample());
      for (int z = 0; z < gen_kz; z++)
         for (int y = 0; y < gen_ky; y++)
            for (int x = 0; x < gen_kx; x++)
               if (!tap_written[tap_addr(x, y, z)])
                  send_item(KIND_TAP, x, y, z, rand_sample());
   endtask

   // Random mix: mostly queries, most inside the volume, plus rewrites and noise
   task automatic random_items(int count);
      int r, x, y, z, axis;
      int open_axes [$];
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         x = $urandom_range(0, 31);
         y = $urandom_range(0, 31);
         z = $urandom_range(0, 31);
         open_axes.delete();
         if (gen_sx < VOL_EDGE) open_axes.push_back(0);
         if (gen_sy < VOL_EDGE) open_axes.push_back(1);
         if (gen_sz < VOL_EDGE) open_axes.push_back(2);
         if (r >= 45 && r < 55 && open_axes.size() != 0) begin
            // query outside the volume on at least one axis
            axis = open_axes[$urandom_range(0, open_axes.size() - 1)];
            case (axis)
               0: x = $urandom_range(gen_sx, 31);
               1: y = $urandom_range(gen_sy, 31);
               default: z = $urandom_range(gen_sz, 31);
            endcase
            send_item(KIND_QUERY, x, y, z, rand_sample());
         end else if (r < 55) begin
            send_item(KIND_QUERY, $urandom_range(0, gen_sx - 1),
                      $urandom_range(0, gen_sy - 1), $urandom_range(0, gen_sz - 1),
                      rand_sample());
         end else if (r < 70) begin
            send_item(KIND_VOXEL, $urandom_range(0, gen_sx - 1),
                      $urandom_range(0, gen_sy - 1), $urandom_range(0, gen_sz - 1),
                      rand_sample());
         end else if (r < 80) begin
            send_item(KIND_TAP, $urandom_range(0, gen_kx - 1),
                      $urandom_range(0, gen_ky - 1), $urandom_range(0, gen_kz - 1),
                      rand_sample());
         end else if (r < 86) begin
            send_item(KIND_VOXEL, x, y, z, rand_sample());
         end else if (r < 93) begin
            // mostly beyond the kernel edge, dropped by the block
            send_item(KIND_TAP, x, y, z, rand_sample());
         end else begin
            send_item(KIND_NONE, x, y, z, rand_sample());
         end
      end
   endtask

   // Stimulus sequence
   initial begin
      int vx, vy, vz;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: full volume, single tap
      send_item(KIND_TAP, 0, 0, 0, -32768);
      send_item(KIND_VOXEL, 0, 0, 0, -32768);
      send_item(KIND_QUERY, 0, 0, 0, 0);
      send_item(KIND_VOXEL, 31, 31, 31, 32767);
      send_item(KIND_QUERY, 31, 31, 31, 0);
      send_item(KIND_TAP, 31, 31, 31, 16'h1234);
      send_item(KIND_TAP, 5, 0, 0, 32767);
      send_item(KIND_NONE, 0, 0, 0, -1);
      send_item(KIND_QUERY, 31, 31, 31, -1);
      send_item(KIND_TAP, 0, 0, 0, 32767);
      send_item(KIND_QUERY, 0, 0, 0, 0);
      send_item(KIND_QUERY, 31, 31, 31, 0);
      send_item(KIND_VOXEL, 5, 17, 9, 12345);
      send_item(KIND_QUERY, 5, 17, 9, 0);

      // Small cube, 3x3x3 kernel: corners, border and outside queries
      configure(4, 4, 4, 3, 3, 3);
      fill_region();
      send_item(KIND_QUERY, 0, 0, 0, 0);
      send_item(KIND_QUERY, 3, 3, 3, 0);
      send_item(KIND_QUERY, 1, 2, 3, 0);
      send_item(KIND_QUERY, 4, 0, 0, 0);
      send_item(KIND_QUERY, 0, 0, 4, 0);
      send_item(KIND_QUERY, 31, 31, 31, 0);
      random_items(RANDOM_PER_PHASE);

      for (int p = 0; p < FIXED_PHASES; p++) begin
         configure(fixed_cfg[p][0], fixed_cfg[p][1], fixed_cfg[p][2],
                   fixed_cfg[p][3], fixed_cfg[p][4], fixed_cfg[p][5]);
         fill_region();
         random_items(RANDOM_PER_PHASE);
      end

      // Random small volumes, raw register values past the limits now and then
      for (int p = 0; p < 5; p++) begin
         do begin
            vx = $urandom_range(1, 32);
            vy = $urandom_range(1, 32);
            vz = $urandom_range(1, 32);
         end while (vx * vy * vz > 96);
         if (vx == 1 && $urandom_range(0, 1)) vx = 0;
         if (vx == 32 && $urandom_range(0, 1)) vx = $urandom_range(33, 63);
         if (vy == 32 && $urandom_range(0, 1)) vy = $urandom_range(33, 63);
         configure(vx, vy, vz, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 63));
         fill_region();
         random_items(RANDOM_PER_PHASE);
      end

      wait_idle();
      if (failures == 0 && queued_sums.size() == 0) begin
         $display("volume_conv_3d_clamped_top test passed");
      end else begin
         $display("volume_conv_3d_clamped_top test failed");
      end
      $finish;
   end

   // Request driver: bursts of random length with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_item  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // Response stall: changing patterns, plus long hold-offs to back up the input
   always @(negedge clock) begin
      stall_tick++;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_seen >= next_hold_at) begin
         next_hold_at += 480;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= stall_tick[1];
         endcase
      end
   end

   // Monitor: register writes, accepted requests and responses
   always @(posedge clock) begin
      if (reset) begin
         cur_vol_x  = VOL_RESET;
         cur_vol_y  = VOL_RESET;
         cur_vol_z  = VOL_RESET;
         cur_taps_x = TAPS_RESET;
         cur_taps_y = TAPS_RESET;
         cur_taps_z = TAPS_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (queued_sums.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("unexpected response: filtered %0d in_range %0b",
                           rsp_item.filtered, rsp_item.in_range);
            end else begin
               want = queued_sums.pop_front();
               if (rsp_item.filtered !== want.filtered ||
                   rsp_item.in_range !== want.in_range) begin
                  failures++;
                  if (failures <= MAX_REPORTS)
                     $display("response mismatch: filtered exp %0d got %0d, in_range exp %0b got %0b",
                              want.filtered, rsp_item.filtered, want.in_range,
                              rsp_item.in_range);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VOL_X:  cur_vol_x  = csr_wdata;
               CSR_VOL_Y:  cur_vol_y  = csr_wdata;
               CSR_VOL_Z:  cur_vol_z  = csr_wdata;
               CSR_TAPS_X: cur_taps_x = csr_wdata[TAPS_W-1:0];
               CSR_TAPS_Y: cur_taps_y = csr_wdata[TAPS_W-1:0];
               CSR_TAPS_Z: cur_taps_z = csr_wdata[TAPS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            case (req_item.kind)
               KIND_TAP: begin
                  if (req_item.pos_x < KER_EDGE && req_item.pos_y < KER_EDGE &&
                      req_item.pos_z < KER_EDGE)
                     tap_mirror[tap_addr(req_item.pos_x, req_item.pos_y,
                                         req_item.pos_z)] = req_item.sample;
               end
               KIND_VOXEL: begin
                  voxel_mirror[voxel_addr(req_item.pos_x, req_item.pos_y,
                                          req_item.pos_z)] = req_item.sample;
               end
               KIND_QUERY: begin
                  queued_sums.push_back(filter_voxel(req_item));
               end
               default: ;
            endcase
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("volume_conv_3d_clamped_top test failed");
         $finish;
      end
   end

endmodule

FILE: sim.f
rtl/core/vcc_pkg.sv
rtl/core/vcc_csr.sv
rtl/core/vcc_ctrl.sv
rtl/core/vcc_dp.sv
rtl/core/volume_conv_3d_clamped_top.sv
sim/tb_volume_conv_3d_clamped_top.sv
